// ===== design/pap_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pap_pkg: shared types and constants of the polygon area preflight
// Field widths, command and status codes, and the structs that travel
// between the pipeline stages.
// ----------------------------------------------------------------------------
package pap_pkg;

	localparam int COORD_BITS  = 24;
	localparam int PROD_BITS   = 2 * COORD_BITS;
	localparam int SUM_BITS    = 61;
	localparam int AREA_BITS   = SUM_BITS - 1;
	localparam int COUNT_BITS  = 16;
	localparam int THRESH_BITS = 20;

	localparam logic [1:0] VERT_FULL = 2'd3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [SUM_BITS-1:0]   sum_t;
	typedef logic [AREA_BITS-1:0]         area_t;
	typedef logic [COUNT_BITS-1:0]        count_t;
	typedef logic [THRESH_BITS-1:0]       thresh_t;

	localparam sum_t SUM_HI = {1'b0, {(SUM_BITS-1){1'b1}}};
	localparam sum_t SUM_LO = {1'b1, {(SUM_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_VERTEX = 2'd0,
		CMD_EMPTY  = 2'd1,
		CMD_EOD    = 2'd2,
		CMD_IGNORE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_VALID  = 3'd0,
		ST_FEW    = 3'd1,
		ST_BAD    = 3'd2,
		ST_ZERO   = 3'd3,
		ST_REPORT = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t   command;
		coord_t x;
		coord_t y;
		logic   coord_bad;
		logic   last_vertex;
	} in_item_t;

	typedef struct packed {
		status_t status;
		area_t   twice_area;
		count_t  contours_seen;
		count_t  valid_count;
		count_t  invalid_count;
		count_t  empty_count;
		area_t   min_twice_area;
		area_t   max_twice_area;
		logic    document_valid;
	} out_item_t;

	typedef struct packed {
		logic report;
		logic start;
		logic finish;
		logic few;
		logic bad;
	} ctl_t;

	typedef struct packed {
		coord_t prev_x;
		coord_t prev_y;
		coord_t cur_x;
		coord_t cur_y;
		coord_t first_x;
		coord_t first_y;
	} ops_t;

	typedef struct packed {
		prod_t run_plus;
		prod_t run_minus;
		prod_t close_plus;
		prod_t close_minus;
	} prods_t;

endpackage

// ===== design/polygon_area_preflight.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_area_preflight: streaming shoelace area check of polygon contours
//
// vtx carries one command per transfer: a vertex, an empty contour marker
// or an end of document. A vertex marked last, an empty marker and an end
// of document each produce one transfer on res; other vertices produce none.
// cfg writes the doubled-area threshold; cfg_ready is always high. Write it
// only while no item is in flight.
// One item is taken per cycle while vtx_ready is high. A result is loaded
// into the res register after its item passes the operand register, product
// register, running sum, closing edge and classification, then the statistics
// update that loads res. The running sum and the statistics each close a
// feedback loop through their own registers.
// When res is stalled, items keep entering until the six stages are full,
// then vtx_ready drops; nothing is lost. Reset empties the pipeline, clears
// contour state and statistics and sets the threshold to zero.
// ----------------------------------------------------------------------------
module polygon_area_preflight
	import pap_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  thresh_t   cfg_data,
	input  logic      vtx_valid,
	output logic      vtx_ready,
	input  in_item_t  vtx,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res
);

	thresh_t threshold_q;

	logic    valid_s2, ready_s2;
	ctl_t    ctl_s2;
	prods_t  prods_s2;
	logic    valid_s4, ready_s4;
	ctl_t    ctl_s4;
	sum_t    sum_s4;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	pap_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vtx_valid  (vtx_valid),
		.vtx_ready  (vtx_ready),
		.vtx        (vtx),
		.valid_s2   (valid_s2),
		.down_ready (ready_s2),
		.ctl_s2     (ctl_s2),
		.prods_s2   (prods_s2)
	);

	pap_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s2   (valid_s2),
		.up_ready   (ready_s2),
		.ctl_s2     (ctl_s2),
		.prods_s2   (prods_s2),
		.valid_s4   (valid_s4),
		.down_ready (ready_s4),
		.ctl_s4     (ctl_s4),
		.sum_s4     (sum_s4)
	);

	pap_stats u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.threshold (threshold_q),
		.valid_s4  (valid_s4),
		.up_ready  (ready_s4),
		.ctl_s4    (ctl_s4),
		.sum_s4    (sum_s4),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

// ===== design/pap_sat_pair.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pap_sat_pair: saturating add then subtract of two cross products
// Each step clamps to the signed sum range before the next one.
// ----------------------------------------------------------------------------
module pap_sat_pair
	import pap_pkg::*;
(
	input  sum_t  acc,
	input  prod_t plus_term,
	input  prod_t minus_term,
	output sum_t  result
);

	logic [SUM_BITS:0] t1;
	logic [SUM_BITS:0] t2;
	sum_t              c1;

	always_comb begin
		t1 = {acc[SUM_BITS-1], acc}
			+ {{(SUM_BITS+1-PROD_BITS){plus_term[PROD_BITS-1]}}, plus_term};
		if (t1[SUM_BITS] != t1[SUM_BITS-1]) begin
			c1 = t1[SUM_BITS] ? SUM_LO : SUM_HI;
		end else begin
			c1 = t1[SUM_BITS-1:0];
		end
		t2 = {c1[SUM_BITS-1], c1}
			- {{(SUM_BITS+1-PROD_BITS){minus_term[PROD_BITS-1]}}, minus_term};
		if (t2[SUM_BITS] != t2[SUM_BITS-1]) begin
			result = t2[SUM_BITS] ? SUM_LO : SUM_HI;
		end else begin
			result = t2[SUM_BITS-1:0];
		end
	end

endmodule

// ===== design/pap_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pap_front: contour tracking, operand register and product stage
// Keeps first and previous vertex per contour, registers the operands
// and forms the four cross products of one vertex.
// ----------------------------------------------------------------------------
module pap_front
	import pap_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     vtx_valid,
	output logic     vtx_ready,
	input  in_item_t vtx,
	output logic     valid_s2,
	input  logic     down_ready,
	output ctl_t     ctl_s2,
	output prods_t   prods_s2
);

	coord_t     first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [1:0] vcount_q;
	logic       bad_q;

	logic       start;
	coord_t     fx, fy;
	logic [1:0] vcount_n;
	logic       bad_n;
	ops_t       ops_d;
	ctl_t       ctl_d;

	logic       valid_s1;
	ctl_t       ctl_s1;
	ops_t       ops_s1;

	logic       ready_s1, ready_s2, take;

	assign ready_s2  = !valid_s2 || down_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign vtx_ready = ready_s1;
	assign take      = vtx_valid && ready_s1;

	always_comb begin
		start    = (vcount_q == 2'd0);
		fx       = start ? vtx.x : first_x_q;
		fy       = start ? vtx.y : first_y_q;
		vcount_n = (vcount_q == VERT_FULL) ? vcount_q : vcount_q + 2'd1;
		bad_n    = bad_q | vtx.coord_bad;
		ops_d    = '{prev_x: prev_x_q, prev_y: prev_y_q, cur_x: vtx.x, cur_y: vtx.y,
			first_x: fx, first_y: fy};
		unique case (vtx.command)
			CMD_VERTEX: ctl_d = '{report: 1'b0, start: start, finish: vtx.last_vertex,
				few: (vcount_n != VERT_FULL), bad: bad_n};
			CMD_EMPTY:  ctl_d = '{report: 1'b0, start: 1'b1, finish: 1'b1,
				few: 1'b1, bad: 1'b0};
			CMD_EOD:    ctl_d = '{report: 1'b1, start: 1'b1, finish: 1'b0,
				few: 1'b0, bad: 1'b0};
			CMD_IGNORE: ctl_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			vcount_q  <= '0;
			bad_q     <= 1'b0;
		end else if (take) begin
			unique case (vtx.command)
				CMD_VERTEX: begin
					if (vtx.last_vertex) begin
						vcount_q <= '0;
						bad_q    <= 1'b0;
					end else begin
						vcount_q  <= vcount_n;
						bad_q     <= bad_n;
						first_x_q <= fx;
						first_y_q <= fy;
						prev_x_q  <= vtx.x;
						prev_y_q  <= vtx.y;
					end
				end
				CMD_EMPTY, CMD_EOD: begin
					vcount_q <= '0;
					bad_q    <= 1'b0;
				end
				CMD_IGNORE: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= vtx_valid && (vtx.command != CMD_IGNORE);
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctl_s1 <= ctl_d;
			ops_s1 <= ops_d;
		end
		if (valid_s1 && ready_s2) begin
			ctl_s2               <= ctl_s1;
			prods_s2.run_plus    <= ops_s1.prev_x * ops_s1.cur_y;
			prods_s2.run_minus   <= ops_s1.cur_x * ops_s1.prev_y;
			prods_s2.close_plus  <= ops_s1.cur_x * ops_s1.first_y;
			prods_s2.close_minus <= ops_s1.first_x * ops_s1.cur_y;
		end
	end

endmodule

// ===== design/pap_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pap_accum: running shoelace sum and closing edge
// Accumulates each vertex's edge into the contour sum, then adds the
// closing edge back to the first vertex for finished contours.
// ----------------------------------------------------------------------------
module pap_accum
	import pap_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   valid_s2,
	output logic   up_ready,
	input  ctl_t   ctl_s2,
	input  prods_t prods_s2,
	output logic   valid_s4,
	input  logic   down_ready,
	output ctl_t   ctl_s4,
	output sum_t   sum_s4
);

	sum_t  cross_q;
	sum_t  run_sum, new_sum, close_sum;

	logic  valid_s3;
	ctl_t  ctl_s3;
	sum_t  sum_s3;
	prod_t close_plus_s3, close_minus_s3;

	logic  ready_s3, ready_s4, take3;

	assign ready_s4 = !valid_s4 || down_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign up_ready = ready_s3;
	assign take3    = valid_s2 && ready_s3;

	pap_sat_pair u_run (
		.acc        (cross_q),
		.plus_term  (prods_s2.run_plus),
		.minus_term (prods_s2.run_minus),
		.result     (run_sum)
	);

	assign new_sum = ctl_s2.start ? '0 : run_sum;

	pap_sat_pair u_close (
		.acc        (sum_s3),
		.plus_term  (close_plus_s3),
		.minus_term (close_minus_s3),
		.result     (close_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cross_q  <= '0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (take3) cross_q <= new_sum;
			if (ready_s3) valid_s3 <= valid_s2 && (ctl_s2.finish || ctl_s2.report);
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (take3) begin
			ctl_s3         <= ctl_s2;
			sum_s3         <= new_sum;
			close_plus_s3  <= prods_s2.close_plus;
			close_minus_s3 <= prods_s2.close_minus;
		end
		if (valid_s3 && ready_s4) begin
			ctl_s4 <= ctl_s3;
			sum_s4 <= close_sum;
		end
	end

endmodule

// ===== design/pap_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pap_stats: contour classification and document statistics
// Turns the closed sum into twice the area and a status, updates the
// saturating counters and area extremes, and holds the result register.
// ----------------------------------------------------------------------------
module pap_stats
	import pap_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  thresh_t   threshold,
	input  logic      valid_s4,
	output logic      up_ready,
	input  ctl_t      ctl_s4,
	input  sum_t      sum_s4,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res
);

	function automatic count_t bump(input count_t c);
		return (c == '1) ? c : c + count_t'(1);
	endfunction

	logic [SUM_BITS-1:0] mag;
	area_t               area;
	logic                zero;
	status_t             status_d;
	area_t               area_d;

	logic    valid_s5;
	status_t status_s5;
	area_t   area_s5;

	count_t  contours_q, valids_q, invalids_q, empties_q;
	area_t   min_q, max_q;
	count_t  contours_n, valids_n, invalids_n, empties_n;
	area_t   min_n, max_n;
	out_item_t out_d;

	logic    ready_s5, ready_s6, take6;

	assign ready_s6 = !res_valid || res_ready;
	assign ready_s5 = !valid_s5 || ready_s6;
	assign up_ready = ready_s5;
	assign take6    = valid_s5 && ready_s6;

	always_comb begin
		mag  = sum_s4[SUM_BITS-1] ? (~sum_s4 + sum_t'(1)) : sum_s4;
		area = mag[AREA_BITS] ? '1 : mag[AREA_BITS-1:0];
		zero = (area <= {{(AREA_BITS-THRESH_BITS){1'b0}}, threshold});
		priority if (ctl_s4.report) begin
			status_d = ST_REPORT;
			area_d   = '0;
		end else if (ctl_s4.few) begin
			status_d = ST_FEW;
			area_d   = '0;
		end else if (ctl_s4.bad) begin
			status_d = ST_BAD;
			area_d   = '0;
		end else if (zero) begin
			status_d = ST_ZERO;
			area_d   = area;
		end else begin
			status_d = ST_VALID;
			area_d   = area;
		end
	end

	always_comb begin
		contours_n = (status_s5 == ST_REPORT) ? contours_q : bump(contours_q);
		valids_n   = valids_q;
		invalids_n = invalids_q;
		empties_n  = empties_q;
		min_n      = min_q;
		max_n      = max_q;
		unique case (status_s5)
			ST_VALID: begin
				valids_n = bump(valids_q);
				if (area_s5 < min_q) min_n = area_s5;
				if (area_s5 > max_q) max_n = area_s5;
			end
			ST_FEW:         empties_n  = bump(empties_q);
			ST_BAD, ST_ZERO: invalids_n = bump(invalids_q);
			ST_REPORT: ;
			default: ;
		endcase
		out_d.status         = status_s5;
		out_d.twice_area     = area_s5;
		out_d.contours_seen  = contours_n;
		out_d.valid_count    = valids_n;
		out_d.invalid_count  = invalids_n;
		out_d.empty_count    = empties_n;
		out_d.min_twice_area = (valids_n != '0) ? min_n : '0;
		out_d.max_twice_area = (valids_n != '0) ? max_n : '0;
		out_d.document_valid = (contours_n != '0) && (invalids_n == '0)
			&& (empties_n == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5   <= 1'b0;
			res_valid  <= 1'b0;
			contours_q <= '0;
			valids_q   <= '0;
			invalids_q <= '0;
			empties_q  <= '0;
			min_q      <= '1;
			max_q      <= '0;
		end else begin
			if (ready_s5) valid_s5 <= valid_s4;
			if (ready_s6) res_valid <= valid_s5;
			if (take6) begin
				if (status_s5 == ST_REPORT) begin
					contours_q <= '0;
					valids_q   <= '0;
					invalids_q <= '0;
					empties_q  <= '0;
					min_q      <= '1;
					max_q      <= '0;
				end else begin
					contours_q <= contours_n;
					valids_q   <= valids_n;
					invalids_q <= invalids_n;
					empties_q  <= empties_n;
					min_q      <= min_n;
					max_q      <= max_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4 && ready_s5) begin
			status_s5 <= status_d;
			area_s5   <= area_d;
		end
		if (take6) res <= out_d;
	end

endmodule

// ===== design/pap_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pap_checker: port-level checks of the polygon area preflight
// Watches the result channel for stall behavior and consistency of the
// reported statistics; bound to the top level.
// ----------------------------------------------------------------------------
module pap_checker
	import pap_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_ready,
	input out_item_t res
);

	count_t last_cnt_q;
	logic   last_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cnt_q <= '0;
			last_ok_q  <= 1'b0;
		end else if (res_valid && res_ready) begin
			last_cnt_q <= res.contours_seen;
			last_ok_q  <= (res.status != ST_REPORT);
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_count_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.valid_count <= res.contours_seen
			&& res.invalid_count <= res.contours_seen
			&& res.empty_count <= res.contours_seen)
		else $error("class count above contour count");

	a_valid_extremes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_VALID |-> res.twice_area != '0
			&& res.min_twice_area <= res.twice_area
			&& res.twice_area <= res.max_twice_area)
		else $error("valid area outside reported extremes");

	a_doc_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.document_valid |-> res.contours_seen != '0
			&& res.valid_count == res.contours_seen)
		else $error("document valid with non-valid contours");

	a_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && last_ok_q |-> res.contours_seen >= last_cnt_q)
		else $error("contour count went down within a document");

endmodule

bind polygon_area_preflight pap_checker u_pap_checker (.*);
